/* design/gnb_pkg.sv */
// ----------------------------------------------------------------------------
// gnb_pkg
// Shared constants for the two-class Gaussian naive Bayes core.
// ----------------------------------------------------------------------------
`default_nettype none

package gnb_pkg;

	// Input item layout
	localparam int NUM_FEAT  = 5;
	localparam int FEAT_W    = 16;
	localparam int IN_BITS   = NUM_FEAT * FEAT_W + 1;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 34;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_W     = 3;

	// Accumulators and counters
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 48;
	localparam int SQ_HALF   = SQ_W / 2;
	localparam int CNT_W     = 17;
	localparam int TALLY_W   = 16;
	localparam int SCORE_W   = 56;
	localparam int NUM_CLS   = 2;
	localparam int ADDR_W    = $clog2(NUM_CLS * NUM_FEAT);
	localparam int F_W       = (NUM_FEAT > 1) ? $clog2(NUM_FEAT) : 1;
	localparam int USED_W    = $clog2(NUM_FEAT + 1);

	localparam logic [CNT_W-1:0]   MAX_TRAIN = 17'd65536;
	localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

	// Log2 / ln constants (Q16 log values, ln2 in Q32)
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;
	localparam logic [21:0] LOG_BASE = 22'd1048576;
	localparam logic [48:0] QUAD_MAX = 49'h1_0000_0000_0000;

	typedef logic signed [FEAT_W-1:0] feat_t;

endpackage

`default_nettype wire

/* design/gaussian_naive_bayes_classifier_core.sv */
// ----------------------------------------------------------------------------
// gaussian_naive_bayes_classifier_core
// Streamed two-class Gaussian naive Bayes: training accumulation and scoring.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per transfer. tuser[0] = 0 trains: the features
//   are added to the sum and square-sum memory of class true_class (a read step
//   and a write step per feature). tuser[0] = 1 tests: both classes are scored
//   and one result transfer goes out on m_axis with the prediction and the
//   updated tallies of the true class.
//   Each used feature of each class needs three divisions on the shared
//   radix-2 divider (variance, |x - mean|, quadratic term) and one log2 pass
//   on the shared 32x32 multiplier; the class count needs one more log2 pass.
//   The block takes one item at a time; s_axis_tready is high while idle. The
//   result sits in an output register, so a new item is taken while it waits.
//   If m_axis stalls, the next test item holds at its decision step until the
//   previous result is taken.
//   The accumulator memory (2 x features entries, registered read) has
//   a valid bit per entry, so reset clears it at once; counts, tallies and
//   features_used (5) reset with arst_n. cfg_we writes features_used.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_naive_bayes_classifier_core (
	input  wire                         clk,
	input  wire                         arst_n,
	// features_used
	input  wire                         cfg_we,
	input  wire [gnb_pkg::CFG_W-1:0]    cfg_wdata,
	// input items
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	// tdata: feature_a, feature_b, feature_c, feature_d, feature_e, true_class, pad
	input  wire [gnb_pkg::IN_W-1:0]     s_axis_tdata,
	// tuser: kind
	input  wire [0:0]                   s_axis_tuser,
	// results
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	// tdata: predicted_class, label_matches, correct_tally, missed_tally, pad
	output logic [gnb_pkg::OUT_W-1:0]   m_axis_tdata
);
	import gnb_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_TR_RD = 5'd1;
	localparam logic [4:0] ST_TR_WR = 5'd2;
	localparam logic [4:0] ST_CLS   = 5'd3;
	localparam logic [4:0] ST_LOGN  = 5'd4;
	localparam logic [4:0] ST_LOGS  = 5'd5;
	localparam logic [4:0] ST_LOGE  = 5'd6;
	localparam logic [4:0] ST_LOGF  = 5'd7;
	localparam logic [4:0] ST_F_RD  = 5'd8;
	localparam logic [4:0] ST_F_MEM = 5'd9;
	localparam logic [4:0] ST_NQL   = 5'd10;
	localparam logic [4:0] ST_SS    = 5'd11;
	localparam logic [4:0] ST_D     = 5'd12;
	localparam logic [4:0] ST_DEN   = 5'd13;
	localparam logic [4:0] ST_DIV   = 5'd14;
	localparam logic [4:0] ST_VCHK  = 5'd15;
	localparam logic [4:0] ST_E     = 5'd16;
	localparam logic [4:0] ST_EE    = 5'd17;
	localparam logic [4:0] ST_QS    = 5'd18;
	localparam logic [4:0] ST_CEND  = 5'd19;
	localparam logic [4:0] ST_DEC   = 5'd20;

	// divider result destinations
	localparam logic [1:0] DR_V = 2'd0;
	localparam logic [1:0] DR_E = 2'd1;
	localparam logic [1:0] DR_Q = 2'd2;

	// log pass destinations
	localparam logic LR_CNT = 1'b0;
	localparam logic LR_VAR = 1'b1;

	localparam int MEM_D = NUM_CLS * NUM_FEAT;

	// control state
	logic [4:0]              state_q;
	logic [F_W-1:0]          f_q;
	logic                    c_q;
	logic                    t_q;
	logic [USED_W-1:0]       used_q;
	logic [CFG_W-1:0]        fu_q;
	logic [CNT_W-1:0]        count_q [NUM_CLS];
	logic [TALLY_W-1:0]      corr_q [NUM_CLS];
	logic [TALLY_W-1:0]      miss_q [NUM_CLS];
	logic [MEM_D-1:0]        vld_q;
	logic                    rd_vld_q;
	logic                    m_valid_q;
	logic [OUT_W-1:0]        out_q;

	// datapath registers
	feat_t                   x_q [NUM_FEAT];
	logic [CNT_W-1:0]        n_q;
	logic [63:0]             prod_q;
	logic [63:0]             acc_q;
	logic signed [SUM_W-1:0] s_q;
	logic [SQ_HALF-1:0]      qlo_q;
	logic [63:0]             v_q;
	logic [48:0]             q_q;
	logic signed [SCORE_W-1:0] tot_q;
	logic signed [SCORE_W-1:0] score_q [NUM_CLS];
	logic [NUM_CLS-1:0]      ok_q;
	logic                    cls_ok_q;
	logic                    hl_neg_q;

	// divider registers
	logic [63:0]             div_rem_q;
	logic [63:0]             div_quo_q;
	logic [63:0]             div_den_q;
	logic [5:0]              div_cnt_q;
	logic [1:0]              div_ret_q;

	// log2 registers
	logic [63:0]             log_v_q;
	logic [5:0]              log_k_q;
	logic [2:0]              log_step_q;
	logic [30:0]             log_m_q;
	logic [15:0]             log_frac_q;
	logic [3:0]              log_cnt_q;
	logic                    log_ret_q;

	// accumulator memory: {square sum, sum}
	logic [SQ_W+SUM_W-1:0]   mem [MEM_D];
	logic [SQ_W+SUM_W-1:0]   rd_data_q;
	logic [ADDR_W-1:0]       addr;
	logic                    mem_we;
	logic [SQ_W+SUM_W-1:0]   mem_wdata;

	// shared multiplier
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             mul_p;

	// misc combinational
	feat_t                   xf;
	logic [FEAT_W-1:0]       xf_mag;
	logic signed [SUM_W-1:0] rd_sum;
	logic [SQ_W-1:0]         rd_sq;
	logic [SUM_W-1:0]        s_mag;
	logic [64:0]             div_r2;
	logic                    div_bit;
	logic [63:0]             div_rem_n;
	logic [5:0]              log_sh;
	logic                    log_top_zero;
	logic [63:0]             log_v_n;
	logic [61:0]             log_sq;
	logic [21:0]             log_l;
	logic [21:0]             log_op;
	logic signed [35:0]      nx_s;
	logic signed [35:0]      r_s;
	logic [35:0]             r_mag;
	logic [63:0]             cnt_rnd;
	logic [63:0]             hl_rnd;
	logic signed [SCORE_W-1:0] hl_s;
	logic                    f_last;
	logic                    pred;
	logic                    match;
	logic [USED_W-1:0]       used_n;

	// current feature and its magnitude
	assign xf     = x_q[f_q];
	assign xf_mag = xf[FEAT_W-1] ? (~xf + FEAT_W'(1)) : xf;

	// masked memory read: never-written entries read as zero
	assign rd_sum = rd_vld_q ? rd_data_q[SUM_W-1:0] : '0;
	assign rd_sq  = rd_vld_q ? rd_data_q[SQ_W+SUM_W-1:SUM_W] : '0;
	assign s_mag  = s_q[SUM_W-1] ? (~s_q + SUM_W'(1)) : s_q;

	// memory address: class row, then feature
	always_comb begin
		logic cls;
		cls  = (state_q == ST_TR_RD || state_q == ST_TR_WR) ? t_q : c_q;
		addr = (cls ? ADDR_W'(NUM_FEAT) : '0) + ADDR_W'(f_q);
	end

	// training write-back
	assign mem_we    = (state_q == ST_TR_WR);
	assign mem_wdata = {rd_sq + SQ_W'(prod_q[31:0]),
		rd_sum + {{(SUM_W-FEAT_W){xf[FEAT_W-1]}}, xf}};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		rd_data_q <= mem[addr];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TR_RD: begin
				mul_a = 32'(xf_mag);
				mul_b = 32'(xf_mag);
			end
			ST_F_MEM: begin
				mul_a = 32'(n_q);
				mul_b = 32'(rd_sq[SQ_W-1:SQ_HALF]);
			end
			ST_NQL: begin
				mul_a = 32'(n_q);
				mul_b = 32'(qlo_q);
			end
			ST_SS: begin
				mul_a = s_mag;
				mul_b = s_mag;
			end
			ST_DEN: begin
				mul_a = 32'(n_q);
				mul_b = 32'(n_q - CNT_W'(1));
			end
			ST_VCHK: begin
				mul_a = 32'(n_q);
				mul_b = 32'(xf_mag);
			end
			ST_EE: begin
				mul_a = 32'(div_quo_q[24:0]);
				mul_b = 32'(div_quo_q[24:0]);
			end
			ST_LOGS: begin
				mul_a = 32'(log_m_q);
				mul_b = 32'(log_m_q);
			end
			ST_LOGE: begin
				mul_a = 32'(log_op);
				mul_b = LN2_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// radix-2 restoring divider step
	assign div_r2    = {div_rem_q, div_quo_q[63]};
	assign div_bit   = (div_r2 >= {1'b0, div_den_q});
	assign div_rem_n = div_bit ? 64'(div_r2 - {1'b0, div_den_q}) : div_r2[63:0];

	// log2 normalize step: shift by 32, 16, ... 1 when the top bits are clear
	assign log_sh       = 6'd32 >> log_step_q;
	assign log_top_zero = ((log_v_q & ~(64'hFFFF_FFFF_FFFF_FFFF >> log_sh)) == '0);
	assign log_v_n      = log_top_zero ? (log_v_q << log_sh) : log_v_q;
	assign log_sq       = mul_p[61:0];
	assign log_l        = {log_k_q, log_frac_q};
	assign log_op       = (log_ret_q == LR_CNT) ? log_l :
		((log_l >= LOG_BASE) ? (log_l - LOG_BASE) : (LOG_BASE - log_l));

	// signed n*x - S and its magnitude
	always_comb begin
		nx_s  = xf[FEAT_W-1] ? -$signed({3'b0, prod_q[32:0]}) : $signed({3'b0, prod_q[32:0]});
		r_s   = nx_s - 36'(s_q);
		r_mag = r_s[35] ? 36'(-r_s) : 36'(r_s);
	end

	// rounding of the ln products
	assign cnt_rnd = prod_q + 64'h8000_0000;
	assign hl_rnd  = prod_q + 64'h1_0000_0000;
	assign hl_s    = hl_neg_q ? -$signed(SCORE_W'(hl_rnd[63:33])) : $signed(SCORE_W'(hl_rnd[63:33]));

	assign f_last = (USED_W'(f_q) + USED_W'(1) == used_q);

	// decision
	assign pred  = ok_q[1] & (~ok_q[0] | (score_q[1] > score_q[0]));
	assign match = (pred == t_q);

	// clamp features_used into 1..NUM_FEAT
	always_comb begin
		if (fu_q == '0) begin
			used_n = USED_W'(1);
		end else if (32'(fu_q) > NUM_FEAT) begin
			used_n = USED_W'(NUM_FEAT);
		end else begin
			used_n = USED_W'(fu_q);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fu_q <= CFG_W'(5);
		end else if (cfg_we) begin
			fu_q <= cfg_wdata;
		end
	end

	// control sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			f_q        <= '0;
			c_q        <= 1'b0;
			t_q        <= 1'b0;
			used_q     <= USED_W'(1);
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			m_valid_q  <= 1'b0;
			out_q      <= '0;
			ok_q       <= '0;
			cls_ok_q   <= 1'b0;
			hl_neg_q   <= 1'b0;
			n_q        <= '0;
			prod_q     <= '0;
			acc_q      <= '0;
			s_q        <= '0;
			qlo_q      <= '0;
			v_q        <= '0;
			q_q        <= '0;
			tot_q      <= '0;
			div_rem_q  <= '0;
			div_quo_q  <= '0;
			div_den_q  <= '0;
			div_cnt_q  <= '0;
			div_ret_q  <= DR_V;
			log_v_q    <= '0;
			log_k_q    <= '0;
			log_step_q <= '0;
			log_m_q    <= '0;
			log_frac_q <= '0;
			log_cnt_q  <= '0;
			log_ret_q  <= LR_CNT;
			for (int i = 0; i < NUM_CLS; i++) begin
				count_q[i] <= '0;
				corr_q[i]  <= '0;
				miss_q[i]  <= '0;
				score_q[i] <= '0;
			end
			for (int i = 0; i < NUM_FEAT; i++) begin
				x_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= vld_q[addr];

			// result register drains on a transfer (the decision step reloads it)
			if (m_valid_q && m_axis_tready && state_q != ST_DEC) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						for (int i = 0; i < NUM_FEAT; i++) begin
							x_q[i] <= s_axis_tdata[i*FEAT_W +: FEAT_W];
						end
						t_q    <= s_axis_tdata[NUM_FEAT*FEAT_W];
						used_q <= used_n;
						f_q    <= '0;
						c_q    <= 1'b0;
						if (s_axis_tuser[0]) begin
							state_q <= ST_CLS;
						end else if (count_q[s_axis_tdata[NUM_FEAT*FEAT_W]] < MAX_TRAIN) begin
							state_q <= ST_TR_RD;
						end
					end
				end

				// training: read entry, square the feature
				ST_TR_RD: begin
					prod_q  <= mul_p;
					state_q <= ST_TR_WR;
				end

				ST_TR_WR: begin
					vld_q[addr] <= 1'b1;
					if (32'(f_q) == NUM_FEAT - 1) begin
						count_q[t_q] <= count_q[t_q] + CNT_W'(1);
						state_q      <= ST_IDLE;
					end else begin
						f_q     <= f_q + F_W'(1);
						state_q <= ST_TR_RD;
					end
				end

				// class start: count check and ln(n)
				ST_CLS: begin
					n_q <= count_q[c_q];
					f_q <= '0;
					if (count_q[c_q] < CNT_W'(2)) begin
						cls_ok_q <= 1'b0;
						state_q  <= ST_CEND;
					end else begin
						log_v_q    <= 64'(count_q[c_q]);
						log_k_q    <= 6'd63;
						log_step_q <= '0;
						log_ret_q  <= LR_CNT;
						state_q    <= ST_LOGN;
					end
				end

				ST_LOGN: begin
					log_v_q <= log_v_n;
					if (log_top_zero) begin
						log_k_q <= log_k_q - log_sh;
					end
					log_step_q <= log_step_q + 3'd1;
					if (log_step_q == 3'd5) begin
						log_m_q    <= log_v_n[63:33];
						log_frac_q <= '0;
						log_cnt_q  <= '0;
						state_q    <= ST_LOGS;
					end
				end

				// one fraction bit per squaring
				ST_LOGS: begin
					if (log_sq[61]) begin
						log_m_q <= log_sq[61:31];
						log_frac_q[4'd15 - log_cnt_q] <= 1'b1;
					end else begin
						log_m_q <= log_sq[60:30];
					end
					log_cnt_q <= log_cnt_q + 4'd1;
					if (log_cnt_q == 4'd15) begin
						state_q <= ST_LOGE;
					end
				end

				ST_LOGE: begin
					prod_q   <= mul_p;
					hl_neg_q <= (log_ret_q == LR_VAR) && (log_l < LOG_BASE);
					state_q  <= ST_LOGF;
				end

				ST_LOGF: begin
					if (log_ret_q == LR_CNT) begin
						tot_q   <= $signed(SCORE_W'(cnt_rnd[63:32]));
						state_q <= ST_F_RD;
					end else begin
						tot_q <= tot_q - hl_s - $signed(SCORE_W'(q_q));
						if (f_last) begin
							cls_ok_q <= 1'b1;
							state_q  <= ST_CEND;
						end else begin
							f_q     <= f_q + F_W'(1);
							state_q <= ST_F_RD;
						end
					end
				end

				// per feature: fetch sums, build n*Q - S*S
				ST_F_RD: begin
					state_q <= ST_F_MEM;
				end

				ST_F_MEM: begin
					s_q     <= rd_sum;
					qlo_q   <= rd_sq[SQ_HALF-1:0];
					prod_q  <= mul_p;
					state_q <= ST_NQL;
				end

				ST_NQL: begin
					acc_q   <= (prod_q << SQ_HALF) + mul_p;
					state_q <= ST_SS;
				end

				ST_SS: begin
					prod_q  <= mul_p;
					state_q <= ST_D;
				end

				ST_D: begin
					if (acc_q <= prod_q) begin
						cls_ok_q <= 1'b0;
						state_q  <= ST_CEND;
					end else begin
						div_quo_q <= acc_q - prod_q;
						state_q   <= ST_DEN;
					end
				end

				ST_DEN: begin
					div_den_q <= mul_p;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					div_ret_q <= DR_V;
					state_q   <= ST_DIV;
				end

				ST_DIV: begin
					div_rem_q <= div_rem_n;
					div_quo_q <= {div_quo_q[62:0], div_bit};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63) begin
						case (div_ret_q)
							DR_V:    state_q <= ST_VCHK;
							DR_E:    state_q <= ST_EE;
							default: state_q <= ST_QS;
						endcase
					end
				end

				// variance check, start n*|x|
				ST_VCHK: begin
					v_q    <= div_quo_q;
					prod_q <= mul_p;
					if (div_quo_q == '0) begin
						cls_ok_q <= 1'b0;
						state_q  <= ST_CEND;
					end else begin
						state_q <= ST_E;
					end
				end

				ST_E: begin
					div_quo_q <= {20'd0, r_mag, 8'd0};
					div_den_q <= 64'(n_q);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					div_ret_q <= DR_E;
					state_q   <= ST_DIV;
				end

				ST_EE: begin
					div_quo_q <= mul_p;
					div_den_q <= {v_q[62:0], 1'b0};
					div_rem_q <= '0;
					div_cnt_q <= '0;
					div_ret_q <= DR_Q;
					state_q   <= ST_DIV;
				end

				// saturate the quadratic term, then ln of the variance
				ST_QS: begin
					q_q        <= (div_quo_q > 64'(QUAD_MAX)) ? QUAD_MAX : div_quo_q[48:0];
					log_v_q    <= v_q;
					log_k_q    <= 6'd63;
					log_step_q <= '0;
					log_ret_q  <= LR_VAR;
					state_q    <= ST_LOGN;
				end

				ST_CEND: begin
					score_q[c_q] <= tot_q;
					ok_q[c_q]    <= cls_ok_q;
					if (!c_q) begin
						c_q     <= 1'b1;
						state_q <= ST_CLS;
					end else begin
						state_q <= ST_DEC;
					end
				end

				// decide, update tallies, load the result register
				ST_DEC: begin
					if (!m_valid_q || m_axis_tready) begin
						logic [TALLY_W-1:0] corr_n;
						logic [TALLY_W-1:0] miss_n;
						corr_n = corr_q[t_q];
						miss_n = miss_q[t_q];
						if (match && corr_n != TALLY_MAX) begin
							corr_n = corr_n + TALLY_W'(1);
						end
						if (!match && miss_n != TALLY_MAX) begin
							miss_n = miss_n + TALLY_W'(1);
						end
						corr_q[t_q] <= corr_n;
						miss_q[t_q] <= miss_n;
						out_q       <= OUT_W'({miss_n, corr_n, match, pred});
						m_valid_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class Gaussian naive Bayes core. Training and
// test samples stream in with random gaps. The checker stalls the result side
// at random. A built-in scorer keeps its own class accumulators, computes the
// expected prediction and tallies, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
	import gnb_pkg::*;

	localparam logic KIND_TRAIN = 1'b0;
	localparam logic KIND_TEST  = 1'b1;
	localparam logic [63:0] LN2 = 64'd2977044472;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic        pred;
		logic        hit;
		logic [15:0] right;
		logic [15:0] wrong;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic [0:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	// scorer state
	logic [63:0] cls_sum [NUM_CLS*NUM_FEAT];
	logic [63:0] cls_sq  [NUM_CLS*NUM_FEAT];
	int unsigned cls_n [NUM_CLS];
	int unsigned right_n [NUM_CLS];
	int unsigned wrong_n [NUM_CLS];
	int unsigned feat_used = 5;

	verdict_t pending_verdicts[$];
	int unsigned fail_cnt = 0;
	bit calm = 1'b0;		// no gaps and no stalls while set

	gaussian_naive_bayes_classifier_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// log2 in Q16 by repeated squaring
	function automatic logic [63:0] log2_fix(logic [63:0] v);
		int k;
		logic [63:0] m, fr;
		k = 63;
		fr = '0;
		while (k > 0 && !v[k])
			k--;
		m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
		for (int i = 1; i <= 16; i++) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				fr[16-i] = 1'b1;
			end
		end
		return (64'(k) << 16) | fr;
	endfunction

	function automatic logic [63:0] abs64(logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// log score of one class; returns 0 for minus infinity
	function automatic bit class_log_score(int c, logic [63:0] x[NUM_FEAT], int unsigned used,
			output longint sc);
		logic [63:0] n, s, sm, nsq, s2, vr, e, q, l, base;
		longint hl;
		n = 64'(cls_n[c]);
		base = 64'd16 << 16;
		sc = 0;
		if (n < 2)
			return 0;
		sc = longint'((log2_fix(n) * LN2 + (64'd1 << 31)) >> 32);
		for (int f = 0; f < used; f++) begin
			s = cls_sum[c*NUM_FEAT+f];
			sm = abs64(s);
			nsq = n * cls_sq[c*NUM_FEAT+f];
			s2 = sm * sm;
			if (nsq <= s2)
				return 0;
			vr = (nsq - s2) / (n * (n - 1));
			if (vr == 0)
				return 0;
			e = abs64(n * x[f] - s) * 256 / n;
			q = (e * e) / (2 * vr);
			if (q > (64'd1 << 48))
				q = 64'd1 << 48;
			l = log2_fix(vr);
			if (l >= base)
				hl = longint'(((l - base) * LN2 + (64'd1 << 32)) >> 33);
			else
				hl = -longint'(((base - l) * LN2 + (64'd1 << 32)) >> 33);
			sc = sc - hl - longint'(q);
		end
		return 1;
	endfunction

	// update the scorer with one accepted sample
	task automatic score_sample(logic kind, logic [FEAT_W-1:0] fv[NUM_FEAT], logic tc);
		logic [63:0] x[NUM_FEAT];
		int unsigned used;
		longint s0, s1;
		bit v0, v1;
		verdict_t vd;
		for (int f = 0; f < NUM_FEAT; f++)
			x[f] = {{48{fv[f][FEAT_W-1]}}, fv[f]};
		if (kind == KIND_TRAIN) begin
			if (cls_n[tc] >= 65536)
				return;
			for (int f = 0; f < NUM_FEAT; f++) begin
				cls_sum[tc*NUM_FEAT+f] += x[f];
				cls_sq[tc*NUM_FEAT+f] += abs64(x[f]) * abs64(x[f]);
			end
			cls_n[tc]++;
			return;
		end
		used = (feat_used < 1) ? 1 : (feat_used > NUM_FEAT) ? NUM_FEAT : feat_used;
		v0 = class_log_score(0, x, used, s0);
		v1 = class_log_score(1, x, used, s1);
		vd.pred = (v1 && (!v0 || s1 > s0));
		vd.hit = (vd.pred == tc);
		if (vd.hit) begin
			if (right_n[tc] < 65535)
				right_n[tc]++;
		end else if (wrong_n[tc] < 65535) begin
			wrong_n[tc]++;
		end
		vd.right = right_n[tc][15:0];
		vd.wrong = wrong_n[tc][15:0];
		pending_verdicts.push_back(vd);
	endtask

	// drive one sample and wait for its transfer
	task automatic send_sample(logic kind, logic [FEAT_W-1:0] fv[NUM_FEAT], logic tc);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, tc, fv[4], fv[3], fv[2], fv[1], fv[0]};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		score_sample(kind, fv, tc);
	endtask

	// wait for an idle block before touching the register
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0 || !s_axis_tready)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_used(int unsigned v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		feat_used = v;
		@(posedge clk);
	endtask

	// sample around a per-class center with a given spread
	task automatic send_near(logic kind, logic tc, int ctr, int spread);
		logic [FEAT_W-1:0] fv[NUM_FEAT];
		for (int f = 0; f < NUM_FEAT; f++)
			fv[f] = FEAT_W'(ctr + f * 64 + $signed($urandom_range(0, 2 * spread)) - spread);
		send_sample(kind, fv, tc);
	endtask

	task automatic send_raw(logic kind, logic tc);
		logic [FEAT_W-1:0] fv[NUM_FEAT];
		for (int f = 0; f < NUM_FEAT; f++)
			fv[f] = FEAT_W'($urandom);
		send_sample(kind, fv, tc);
	endtask

	// result side: random stalls and field checks
	int stall_left = 0;
	always @(posedge clk) begin
		verdict_t vd;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result transfer with nothing pending: %h", m_axis_tdata);
				fail_cnt++;
			end else begin
				vd = pending_verdicts.pop_front();
				if (m_axis_tdata[0] !== vd.pred) begin
					$error("predicted_class exp %0d got %0d", vd.pred, m_axis_tdata[0]);
					fail_cnt++;
				end
				if (m_axis_tdata[1] !== vd.hit) begin
					$error("label_matches exp %0d got %0d", vd.hit, m_axis_tdata[1]);
					fail_cnt++;
				end
				if (m_axis_tdata[17:2] !== vd.right) begin
					$error("correct_tally exp %0d got %0d", vd.right, m_axis_tdata[17:2]);
					fail_cnt++;
				end
				if (m_axis_tdata[33:18] !== vd.wrong) begin
					$error("missed_tally exp %0d got %0d", vd.wrong, m_axis_tdata[33:18]);
					fail_cnt++;
				end
			end
			stall_left <= calm ? 0 : $urandom_range(0, 5);
			m_axis_tready <= (calm || $urandom_range(0, 5) == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// tests right after reset: too few samples, then exactly one sample
	task automatic test_too_few();
		send_raw(KIND_TEST, 1'b0);
		send_raw(KIND_TEST, 1'b1);
		send_near(KIND_TRAIN, 1'b1, 500, 100);
		send_raw(KIND_TEST, 1'b1);
	endtask

	// class 0 gets identical samples: zero variance
	task automatic test_zero_variance();
		logic [FEAT_W-1:0] fv[NUM_FEAT];
		for (int f = 0; f < NUM_FEAT; f++)
			fv[f] = FEAT_W'(300 * f);
		repeat (3) send_sample(KIND_TRAIN, fv, 1'b0);
		send_near(KIND_TRAIN, 1'b1, 500, 100);
		send_near(KIND_TEST, 1'b0, 0, 50);
		send_near(KIND_TEST, 1'b1, 500, 50);
	endtask

	// full-scale features on both classes
	task automatic test_extremes();
		logic [FEAT_W-1:0] lo[NUM_FEAT], hi[NUM_FEAT], mix[NUM_FEAT];
		for (int f = 0; f < NUM_FEAT; f++) begin
			lo[f] = 16'h8000;
			hi[f] = 16'h7FFF;
			mix[f] = f[0] ? 16'hFFFF : 16'h0000;
		end
		send_sample(KIND_TRAIN, lo, 1'b0);
		send_sample(KIND_TRAIN, hi, 1'b0);
		send_sample(KIND_TRAIN, mix, 1'b0);
		send_sample(KIND_TRAIN, hi, 1'b1);
		send_sample(KIND_TRAIN, mix, 1'b1);
		send_sample(KIND_TEST, lo, 1'b0);
		send_sample(KIND_TEST, hi, 1'b1);
		send_sample(KIND_TEST, mix, 1'b1);
	endtask

	// every register value, the out-of-range ones included
	task automatic test_feature_counts();
		for (int v = 0; v < 8; v++) begin
			write_used(v);
			send_near(KIND_TEST, v[0], v[0] ? 500 : 0, 200);
		end
	endtask

	// random phases of mostly well-formed class clusters
	task automatic test_random(int n_items);
		int sent, ctr0, ctr1, spread, r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 9);
			write_used(r < 6 ? $urandom_range(1, 2) : $urandom_range(0, 7));
			calm = ($urandom_range(0, 3) == 0);
			ctr0 = $urandom_range(0, 4000) - 2000;
			ctr1 = $urandom_range(0, 4000) - 2000;
			spread = $urandom_range(1, 3000);
			repeat (60) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_raw($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
				else if (r < 70)
					send_near(KIND_TRAIN, r[0], r[0] ? ctr1 : ctr0, spread);
				else
					send_near(KIND_TEST, r[0], r[0] ? ctr1 : ctr0, spread + 500);
				sent++;
			end
			calm = 1'b0;
		end
	endtask

	// drive class 1 to its sample limit, then past it
	task automatic test_full_class();
		settle();
		calm = 1'b1;
		while (cls_n[1] < 65536)
			send_near(KIND_TRAIN, 1'b1, 200, 800);
		repeat (3) send_near(KIND_TRAIN, 1'b1, 200, 800);
		calm = 1'b0;
		write_used(5);
		send_near(KIND_TEST, 1'b1, 200, 400);
		send_near(KIND_TEST, 1'b0, 200, 400);
	endtask

	initial begin
		for (int i = 0; i < NUM_CLS * NUM_FEAT; i++) begin
			cls_sum[i] = '0;
			cls_sq[i] = '0;
		end
		for (int c = 0; c < NUM_CLS; c++) begin
			cls_n[c] = 0;
			right_n[c] = 0;
			wrong_n[c] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_too_few();
		test_zero_variance();
		test_extremes();
		test_feature_counts();
		test_random(2000);
		test_full_class();
		settle();
		if (fail_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#400ms;
		$display("tb failed");
		$finish;
	end

endmodule
